// ===== hw/rtl/owur_pkg.sv =====
// Package: shared types, phase codes and constants for the single-wire UART request reader.
`default_nettype none
package owur_pkg;

    localparam int PERIOD_BITS_DEF = 16;
    localparam int CODE_BITS = 8;
    localparam int RESP_BITS = 16;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;

    localparam logic [3:0] TX_BITS = 4'd10;
    localparam logic [3:0] RX_BITS = 4'd8;
    localparam logic [3:0] STOP_BIT_IDX = 4'd9;

    localparam int BIT_PERIOD_RESET = 104;
    localparam logic [CODE_BITS-1:0] REQUEST_CODE_RESET = 8'd80;

    localparam logic REG_BIT_PERIOD = 1'b0;
    localparam logic REG_REQUEST_CODE = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_TX     = 5'b00010,
        PH_WAIT   = 5'b00100,
        PH_SAMPLE = 5'b01000,
        PH_GAP    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic                 line_out;
        logic                 drive_enable;
        logic                 busy_res;
        logic                 done_res;
        logic [RESP_BITS-1:0] response;
    } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/owur_cfg.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none
module owur_cfg #(
    parameter int PERIOD_BITS = owur_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [owur_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [owur_pkg::DATA_BITS-1:0]      pwdata,
    output logic      [owur_pkg::DATA_BITS-1:0]      prdata,
    output logic                                     pready,
    output logic      [PERIOD_BITS-1:0]              bit_period,
    output logic      [owur_pkg::CODE_BITS-1:0]      request_code
);

    logic [PERIOD_BITS-1:0]         bit_period_reg;
    logic [owur_pkg::CODE_BITS-1:0] request_code_reg;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg   <= PERIOD_BITS'(owur_pkg::BIT_PERIOD_RESET);
            request_code_reg <= owur_pkg::REQUEST_CODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                owur_pkg::REG_BIT_PERIOD:
                    bit_period_reg <= pwdata[PERIOD_BITS-1:0];
                owur_pkg::REG_REQUEST_CODE:
                    request_code_reg <= pwdata[owur_pkg::CODE_BITS-1:0];
                default:
                    bit_period_reg <= bit_period_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            owur_pkg::REG_BIT_PERIOD:
                prdata = owur_pkg::DATA_BITS'(bit_period_reg);
            owur_pkg::REG_REQUEST_CODE:
                prdata = owur_pkg::DATA_BITS'(request_code_reg);
            default:
                prdata = '0;
        endcase
    end

    assign bit_period   = bit_period_reg;
    assign request_code = request_code_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/owur_core.sv =====
// Transaction state and per-tick next-state and result logic.
`default_nettype none
module owur_core #(
    parameter int PERIOD_BITS = owur_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic                           start_req,
    input  wire logic                           line_in,
    input  wire logic [PERIOD_BITS-1:0]         bit_period,
    input  wire logic [owur_pkg::CODE_BITS-1:0] request_code,
    output owur_pkg::res_t                      res
);

    localparam int TW = PERIOD_BITS + 2;

    owur_pkg::phase_t               phase_reg, phase_next;
    logic [TW-1:0]                  tick_reg, tick_next;
    logic [3:0]                     bit_reg, bit_next;
    logic [7:0]                     shift_reg, shift_next;
    logic [7:0]                     first_reg, first_next;
    logic                           byte_reg, byte_next;

    logic [TW-1:0]                  tick_inc;
    logic [TW-1:0]                  p_ext;
    logic [TW-1:0]                  p_x3;
    logic [TW-1:0]                  p_x2;
    logic [TW-1:0]                  p_first;
    logic [TW-1:0]                  target;
    logic [3:0]                     bit_inc;
    logic [2:0]                     code_idx;
    logic                           done;
    logic [owur_pkg::RESP_BITS-1:0] resp;
    logic                           drive;
    logic                           level;

    always_comb
    begin
        p_ext    = TW'(bit_period);
        p_x2     = p_ext << 1;
        p_x3     = p_ext + p_x2;
        p_first  = p_ext + (p_ext >> 1);
        target   = (bit_reg == 4'd0) ? p_first : p_ext;
        tick_inc = tick_reg + TW'(1);
        bit_inc  = bit_reg + 4'd1;

        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        first_next = first_reg;
        byte_next  = byte_reg;
        done       = 1'b0;
        resp       = '0;

        unique case (phase_reg)
            owur_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    if (bit_period == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = owur_pkg::PH_TX;
                        bit_next   = 4'd0;
                        tick_next  = TW'(1);
                    end
                end
            end
            owur_pkg::PH_TX:
            begin
                if (tick_reg >= p_ext)
                begin
                    if (bit_inc >= owur_pkg::TX_BITS)
                    begin
                        phase_next = owur_pkg::PH_WAIT;
                        bit_next   = 4'd0;
                        tick_next  = '0;
                    end
                    else
                    begin
                        bit_next  = bit_inc;
                        tick_next = TW'(1);
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            owur_pkg::PH_WAIT:
            begin
                tick_next = tick_inc;
                if (!line_in || tick_inc >= p_x3)
                begin
                    phase_next = owur_pkg::PH_SAMPLE;
                    bit_next   = 4'd0;
                    shift_next = '0;
                    tick_next  = '0;
                end
            end
            owur_pkg::PH_SAMPLE:
            begin
                tick_next = tick_inc;
                if (tick_inc >= target)
                begin
                    shift_next              = shift_reg;
                    shift_next[bit_reg[2:0]] = shift_reg[bit_reg[2:0]] | line_in;
                    tick_next               = '0;
                    bit_next                = bit_inc;
                    if (bit_inc >= owur_pkg::RX_BITS)
                    begin
                        phase_next = owur_pkg::PH_GAP;
                        bit_next   = 4'd0;
                    end
                end
            end
            owur_pkg::PH_GAP:
            begin
                tick_next = tick_inc;
                if (tick_inc >= p_x2)
                begin
                    tick_next = '0;
                    if (!byte_reg)
                    begin
                        first_next = shift_reg;
                        byte_next  = 1'b1;
                        phase_next = owur_pkg::PH_WAIT;
                    end
                    else
                    begin
                        done       = 1'b1;
                        resp       = {first_reg, shift_reg};
                        byte_next  = 1'b0;
                        phase_next = owur_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = owur_pkg::PH_IDLE;
                tick_next  = '0;
                bit_next   = 4'd0;
            end
        endcase

        drive    = (phase_next == owur_pkg::PH_TX);
        code_idx = 3'(bit_next - 4'd1);
        if (bit_next == 4'd0)
        begin
            level = 1'b0;
        end
        else if (bit_next >= owur_pkg::STOP_BIT_IDX)
        begin
            level = 1'b1;
        end
        else
        begin
            level = request_code[code_idx];
        end

        res.line_out     = drive & level;
        res.drive_enable = drive;
        res.busy_res     = (phase_next != owur_pkg::PH_IDLE);
        res.done_res     = done;
        res.response     = resp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= owur_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            first_reg <= '0;
            byte_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            first_reg <= first_next;
            byte_reg  <= byte_next;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == owur_pkg::PH_IDLE)
        else $error("done item left a transaction open");

    a_drive_in_tx: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.drive_enable |=> phase_reg == owur_pkg::PH_TX && bit_reg < owur_pkg::TX_BITS)
        else $error("wire driven outside the transmit phase");

    a_rx_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == owur_pkg::PH_SAMPLE |-> bit_reg < owur_pkg::RX_BITS)
        else $error("receive bit index out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/owur_obuf.sv =====
// Result register with a skid stage toward the output stream.
`default_nettype none
module owur_obuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  owur_pkg::res_t      push_data,
    output logic                can_push,
    output logic                out_valid,
    input  wire logic           out_ready,
    output owur_pkg::res_t      out_data
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    owur_pkg::res_t main_data_reg, main_data_next;
    owur_pkg::res_t skid_data_reg, skid_data_next;
    logic           pop;

    assign pop      = main_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_data_next  = push_data;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds an item ahead of the result register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        push && main_valid_reg && !pop |=> skid_valid_reg && skid_data_reg == $past(push_data))
        else $error("pushed item lost while output stalled");

endmodule
`default_nettype wire

// ===== hw/rtl/one_wire_uart_request_reader.sv =====
// Top level: single-wire half-duplex UART request reader with stream and APB ports.
// A result item for an accepted tick is registered in the result register or the skid stage.
// Throughput: one tick item per cycle while the skid stage is empty; the per-tick logic runs
// between state and result registers; a skid stage keeps input open for one stalled result.
// Reset (rst_n low, asynchronous): phase idle, counters cleared, output stream empty,
// bit_period 104 and request_code 80.
`default_nettype none
module one_wire_uart_request_reader #(
    parameter int PERIOD_BITS = owur_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // [0] start_req, [1] line_in
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [23:0]                    m_tdata,  // [0] line_out, [1] drive_enable,
                                                          // [2] busy_res, [3] done_res,
                                                          // [19:4] response
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [owur_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [owur_pkg::DATA_BITS-1:0] pwdata,
    output logic      [owur_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready
);

    logic [PERIOD_BITS-1:0]         bit_period;
    logic [owur_pkg::CODE_BITS-1:0] request_code;
    logic                           accept;
    owur_pkg::res_t                 step_res;
    owur_pkg::res_t                 out_res;

    assign accept = s_tvalid && s_tready;

    owur_cfg #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .bit_period   (bit_period),
        .request_code (request_code)
    );

    owur_core #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .start_req    (s_tdata[0]),
        .line_in      (s_tdata[1]),
        .bit_period   (bit_period),
        .request_code (request_code),
        .res          (step_res)
    );

    owur_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {4'b0000, out_res.response, out_res.done_res, out_res.busy_res,
                      out_res.drive_enable, out_res.line_out};

endmodule
`default_nettype wire

// ===== bench/one_wire_uart_request_reader_tb.sv =====
// Testbench for the single-wire UART request reader: random tick streams with per-tick result checks.
module one_wire_uart_request_reader_tb;
    import owur_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic line;
        logic start;
    } tick_t;

    class reading_tracker;
        int unsigned          period = BIT_PERIOD_RESET;
        logic [CODE_BITS-1:0] code = REQUEST_CODE_RESET;
        phase_t               step = PH_IDLE;
        logic [17:0]          bit_timer = '0;
        logic [3:0]           bit_pos = '0;
        logic [7:0]           rx_byte = '0;
        logic [7:0]           held_byte = '0;
        logic                 on_second = 1'b0;
        res_t                 expected_results[$];
        int unsigned          results_seen = 0;
        int unsigned          failures = 0;

        function void set_reg(logic sel, logic [31:0] value);
            if (sel == REG_BIT_PERIOD)
                period = value[15:0];
            else
                code = value[CODE_BITS-1:0];
        endfunction

        function void take_tick(tick_t t);
            int unsigned p;
            int unsigned target;
            logic        done;
            logic [15:0] word;
            res_t        r;
            p = period;
            done = 1'b0;
            word = '0;
            case (step)
                PH_IDLE:
                    if (t.start) begin
                        if (p == 0)
                            done = 1'b1;
                        else begin
                            step = PH_TX;
                            bit_pos = '0;
                            bit_timer = 18'd1;
                        end
                    end
                PH_TX:
                    if (bit_timer >= p) begin
                        bit_pos = bit_pos + 4'd1;
                        if (bit_pos >= TX_BITS) begin
                            step = PH_WAIT;
                            bit_pos = '0;
                            bit_timer = '0;
                        end else
                            bit_timer = 18'd1;
                    end else
                        bit_timer = bit_timer + 18'd1;
                PH_WAIT: begin
                    bit_timer = bit_timer + 18'd1;
                    if (!t.line || bit_timer >= 3 * p) begin
                        step = PH_SAMPLE;
                        bit_pos = '0;
                        rx_byte = '0;
                        bit_timer = '0;
                    end
                end
                PH_SAMPLE: begin
                    target = (bit_pos == 0) ? p + p / 2 : p;
                    bit_timer = bit_timer + 18'd1;
                    if (bit_timer >= target) begin
                        rx_byte[bit_pos[2:0]] = t.line;
                        bit_pos = bit_pos + 4'd1;
                        bit_timer = '0;
                        if (bit_pos >= RX_BITS) begin
                            step = PH_GAP;
                            bit_pos = '0;
                        end
                    end
                end
                PH_GAP: begin
                    bit_timer = bit_timer + 18'd1;
                    if (bit_timer >= 2 * p) begin
                        bit_timer = '0;
                        if (!on_second) begin
                            held_byte = rx_byte;
                            on_second = 1'b1;
                            step = PH_WAIT;
                        end else begin
                            done = 1'b1;
                            word = {held_byte, rx_byte};
                            on_second = 1'b0;
                            step = PH_IDLE;
                        end
                    end
                end
                default: begin
                    step = PH_IDLE;
                    bit_timer = '0;
                    bit_pos = '0;
                end
            endcase
            r.drive_enable = (step == PH_TX);
            if (!r.drive_enable || bit_pos == 0)
                r.line_out = 1'b0;
            else if (bit_pos >= STOP_BIT_IDX)
                r.line_out = 1'b1;
            else
                r.line_out = code[bit_pos - 4'd1];
            r.busy_res = (step != PH_IDLE);
            r.done_res = done;
            r.response = done ? word : 16'h0000;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [23:0] data);
            res_t want;
            res_t got;
            got.line_out = data[0];
            got.drive_enable = data[1];
            got.busy_res = data[2];
            got.done_res = data[3];
            got.response = data[19:4];
            results_seen++;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with nothing pending: %h", results_seen, data);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d mismatch: expected out=%b drv=%b busy=%b done=%b resp=%h,",
                             results_seen, want.line_out, want.drive_enable, want.busy_res,
                             want.done_res, want.response,
                             " got out=%b drv=%b busy=%b done=%b resp=%h",
                             got.line_out, got.drive_enable,
                             got.busy_res, got.done_res, got.response);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    reading_tracker tracker = new();
    tick_t          pending_ticks[$];
    int unsigned    issued = 0;
    int unsigned    accepted = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    int unsigned    glitch_pct = 0;
    int unsigned    hold_left = 0;
    int unsigned    cycles = 0;

    one_wire_uart_request_reader u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic push_tick(input logic start, input logic line);
        tick_t t;
        t.start = start;
        t.line = line;
        pending_ticks.push_back(t);
        issued++;
    endtask

    task automatic push_run(input logic level, input int unsigned count, input logic strays);
        repeat (count)
            push_tick(strays && $urandom_range(63) == 0,
                      ($urandom_range(99) < glitch_pct) ? !level : level);
    endtask

    task automatic push_byte(input int unsigned p, input logic [7:0] value);
        push_run(1'b0, p, 1'b1);
        for (int i = 0; i < 8; i++)
            push_run(value[i], p, 1'b1);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_request(input int unsigned p);
        int unsigned lead;
        if (p == 0)
            push_tick(1'b1, 1'($urandom_range(1)));
        else begin
            lead = ($urandom_range(7) == 0) ? 3 * p + $urandom_range(1, 4)
                                            : $urandom_range(0, p);
            push_tick(1'b1, 1'b1);
            push_run(1'b1, 10 * p + lead, 1'b1);
            push_byte(p, pick_byte());
            push_run(1'b1, 2 * p + 1 + $urandom_range(0, p), 1'b1);
            push_byte(p, pick_byte());
            push_run(1'b1, 2 * p + 2 + $urandom_range(0, 3), 1'b0);
        end
    endtask

    task automatic apb_write(input logic sel, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_reg(sel, value);
    endtask

    task automatic wait_drained();
        while (accepted != issued || tracker.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_segment(input int unsigned n_req);
        int unsigned          p;
        int unsigned          pick;
        logic [CODE_BITS-1:0] req_code;
        pick = $urandom_range(99);
        if (pick < 6)
            p = 0;
        else if (pick < 60)
            p = $urandom_range(1, 2);
        else if (pick < 92)
            p = $urandom_range(3, 4);
        else
            p = $urandom_range(5, 7);
        pick = $urandom_range(3);
        req_code = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        apb_write(REG_BIT_PERIOD, {16'($urandom), 16'(p)});
        apb_write(REG_REQUEST_CODE, {24'($urandom), req_code});
        repeat (n_req) begin
            glitch_pct = ($urandom_range(3) == 0) ? 3 : 0;
            repeat ($urandom_range(0, 4))
                push_tick(1'b0, 1'($urandom_range(1)));
            push_request(p);
        end
        glitch_pct = 0;
        wait_drained();
    endtask

    initial
    begin
        tick_t held;
        held = '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        forever begin
            @(posedge clk);
            if (s_tvalid && s_tready) begin
                tracker.take_tick(held);
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b000000, held.line, held.start};
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[one_wire_uart_request_reader] ERROR");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start under reset settings
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        wait_drained();

        // oversized writes, longest period
        apb_write(REG_BIT_PERIOD, 32'hFFFF_FFFF);
        apb_write(REG_REQUEST_CODE, 32'hFFFF_FFFF);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        wait_drained();

        // zero period mid-transaction, then immediate completions
        apb_write(REG_BIT_PERIOD, 32'h0000_0000);
        repeat (32)
            push_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        wait_drained();

        send_idle_pct = 30;
        recv_idle_pct = 73;
        repeat (4) run_segment(2);

        send_idle_pct = 73;
        recv_idle_pct = 30;
        repeat (4) run_segment(2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 400;
        repeat (4) run_segment(2);

        repeat (8) @(posedge clk);
        if (tracker.expected_results.size() != 0)
            $display("%0d results never arrived", tracker.expected_results.size());
        if (tracker.failures == 0 && tracker.expected_results.size() == 0)
            $display("[one_wire_uart_request_reader] OK");
        else
            $display("[one_wire_uart_request_reader] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/owur_pkg.sv
hw/rtl/owur_cfg.sv
hw/rtl/owur_core.sv
hw/rtl/owur_obuf.sv
hw/rtl/one_wire_uart_request_reader.sv
bench/one_wire_uart_request_reader_tb.sv
